### design/bfc_pkg.sv
package bfc_pkg;

	// Ring geometry; DEPTH is kept a multiple of LANES so that consecutive bytes fall
	// into distinct lanes, also across the wrap.
	localparam int DEPTH      = 1024;
	localparam int LANES      = 4;
	localparam int LANE_W     = 2;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int SUM_W      = PTR_W + 1;
	localparam int CNT_W      = $clog2(DEPTH + 1);
	localparam int OFS_W      = 10;
	localparam int EXT_W      = ((PTR_W > OFS_W) ? PTR_W : OFS_W) + 1;
	localparam int BANK_DEPTH = DEPTH / LANES;

	localparam logic [2:0] CMD_PUSH       = 3'd0;
	localparam logic [2:0] CMD_POP        = 3'd1;
	localparam logic [2:0] CMD_PEEK       = 3'd2;
	localparam logic [2:0] CMD_CLEAR      = 3'd3;
	localparam logic [2:0] CMD_SET_POPPED = 3'd4;
	localparam logic [2:0] CMD_SET_QUEUED = 3'd5;

	typedef struct packed {
		logic [2:0]  command;
		logic [31:0] push_data;
		logic [2:0]  byte_count;
		logic [9:0]  peek_offset;
		logic [7:0]  new_checksum;
	} in_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic [7:0]  old_checksum;
		logic [10:0] fill_level;
		logic        is_empty;
		logic        overflowed;
		logic [7:0]  popped_sum;
		logic [7:0]  queued_sum;
	} out_t;

	typedef struct packed {
		logic             en;
		logic             wr;
		logic [PTR_W-1:0] start;
		logic [2:0]       count;
		logic [31:0]      data;
	} lane_req_t;

	typedef enum logic {
		ST_IDLE,
		ST_DONE
	} st_t;

	function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] p,
			input logic [2:0] k);
		logic [SUM_W-1:0] s;
		s = {1'b0, p} + SUM_W'(k);
		if (s >= SUM_W'(DEPTH)) begin
			s = s - SUM_W'(DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	// Zero every byte at or above position k.
	function automatic logic [31:0] mask_bytes(input logic [31:0] w, input logic [2:0] k);
		logic [31:0] r;
		for (int i = 0; i < 4; i++) begin
			r[8*i +: 8] = (3'(i) < k) ? w[8*i +: 8] : 8'h00;
		end
		return r;
	endfunction

	function automatic logic [7:0] byte_sum(input logic [31:0] w);
		logic [7:0] s;
		s = 8'h00;
		for (int i = 0; i < 4; i++) begin
			s = s + w[8*i +: 8];
		end
		return s;
	endfunction

endpackage

### design/byte_fifo_with_checksums_top.sv
// Byte queue in a ring of DEPTH bytes with running 8-bit sums of pushed and popped bytes.
// Each input word carries one command (push, pop or peek of up to 4 bytes, clear, or load
// of either checksum) and yields exactly one result word with the read bytes and status.
// The ring is split into four byte-wide banks, one per lane, so all bytes of a word are
// written or read in the same cycle. The accept cycle drives the banks, and the
// registered bank read is merged into the output register once that register is free.
// A new word is taken only once the last one has gone into the output register; a stalled
// result holds in the output register, and one more input word may be accepted behind it.
// Bank contents are undefined after reset and need no clearing pass: only written bytes
// are ever returned, since reads past the fill level come back as zero.
module byte_fifo_with_checksums_top (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  bfc_pkg::in_t    in_word,
	output logic            out_valid,
	input  logic            out_ready,
	output bfc_pkg::out_t   out_word
);

	localparam int EXT_W = bfc_pkg::EXT_W;
	localparam int CNT_W = bfc_pkg::CNT_W;
	localparam int PTR_W = bfc_pkg::PTR_W;

	bfc_pkg::st_t state_q, state_d;

	logic [PTR_W-1:0] head_q, tail_q;
	logic [CNT_W-1:0] held_q;
	logic [7:0]       pop_sum_q, que_sum_q;

	// Item captured at accept, used when the result is formed.
	logic [2:0]                 cmd_q;
	logic [2:0]                 k_q;
	logic [bfc_pkg::LANE_W-1:0] lo_q;
	logic                       ovf_q;
	logic [7:0]                 old_q;

	bfc_pkg::out_t out_q;
	logic          out_valid_q;

	logic accept;
	logic load;

	logic [2:0]       n;
	logic [CNT_W-1:0] room;
	logic [2:0]       push_k, pop_k, peek_k;
	logic             ovf;
	logic [EXT_W-1:0] base_e, held_e, ofs_e, avail;
	logic [PTR_W-1:0] peek_base;

	bfc_pkg::lane_req_t            req;
	logic [bfc_pkg::LANES-1:0][7:0] lane_rd;
	logic [31:0]                   mrg_data;
	logic [7:0]                    mrg_sum;

	assign accept = in_valid & in_ready;

	// Work out how many bytes this command really moves and where it starts.
	always_comb begin
		n    = (in_word.byte_count > 3'd4) ? 3'd4 : in_word.byte_count;
		room = CNT_W'(bfc_pkg::DEPTH) - held_q;
		ovf  = CNT_W'(n) > room;
		push_k = ovf ? room[2:0] : n;
		pop_k  = (held_q < CNT_W'(n)) ? held_q[2:0] : n;

		held_e = EXT_W'(held_q);
		ofs_e  = EXT_W'(in_word.peek_offset);
		avail  = (held_e > ofs_e) ? held_e - ofs_e : '0;
		peek_k = (avail < EXT_W'(n)) ? avail[2:0] : n;
		// Only used when offset lies below the fill level, so one wrap suffices.
		base_e = EXT_W'(head_q) + ofs_e;
		if (base_e >= EXT_W'(bfc_pkg::DEPTH)) begin
			base_e = base_e - EXT_W'(bfc_pkg::DEPTH);
		end
		peek_base = base_e[PTR_W-1:0];

		req.en    = 1'b0;
		req.wr    = 1'b0;
		req.start = head_q;
		req.count = 3'd0;
		req.data  = in_word.push_data;
		unique case (in_word.command)
			bfc_pkg::CMD_PUSH: begin
				req.en    = accept;
				req.wr    = 1'b1;
				req.start = tail_q;
				req.count = push_k;
			end
			bfc_pkg::CMD_POP: begin
				req.en    = accept;
				req.count = pop_k;
			end
			bfc_pkg::CMD_PEEK: begin
				req.en    = accept;
				req.start = peek_base;
				req.count = peek_k;
			end
			default: begin
				req.en = 1'b0;
			end
		endcase
	end

	for (genvar g = 0; g < bfc_pkg::LANES; g++) begin : g_lane
		bfc_lane u_lane (
			.clk    (clk),
			.lane_id(bfc_pkg::LANE_W'(g)),
			.req    (req),
			.rdata  (lane_rd[g])
		);
	end

	bfc_merge u_merge (
		.lane_rd  (lane_rd),
		.start_lo (lo_q),
		.count    (k_q),
		.read_data(mrg_data),
		.sum      (mrg_sum)
	);

	// Sequencer: take a word in idle, finish it once the output register is free.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load     = 1'b0;
		unique case (state_q)
			bfc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = bfc_pkg::ST_DONE;
				end
			end
			bfc_pkg::ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					load    = 1'b1;
					state_d = bfc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bfc_pkg::ST_IDLE;
			end
		endcase
	end

	// Queue state: pointers and counts advance at accept, the popped sum when the
	// read bytes come back from the banks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			tail_q    <= '0;
			held_q    <= '0;
			pop_sum_q <= 8'h00;
			que_sum_q <= 8'h00;
		end else begin
			if (accept) begin
				unique case (in_word.command)
					bfc_pkg::CMD_PUSH: begin
						tail_q    <= bfc_pkg::ring_add(tail_q, push_k);
						held_q    <= held_q + CNT_W'(push_k);
						que_sum_q <= que_sum_q + bfc_pkg::byte_sum(
							bfc_pkg::mask_bytes(in_word.push_data, push_k));
					end
					bfc_pkg::CMD_POP: begin
						head_q <= bfc_pkg::ring_add(head_q, pop_k);
						held_q <= held_q - CNT_W'(pop_k);
					end
					bfc_pkg::CMD_CLEAR: begin
						head_q <= '0;
						tail_q <= '0;
						held_q <= '0;
					end
					bfc_pkg::CMD_SET_POPPED: begin
						pop_sum_q <= in_word.new_checksum;
					end
					bfc_pkg::CMD_SET_QUEUED: begin
						que_sum_q <= in_word.new_checksum;
					end
					default: begin
						held_q <= held_q;
					end
				endcase
			end
			if (load && cmd_q == bfc_pkg::CMD_POP) begin
				pop_sum_q <= pop_sum_q + mrg_sum;
			end
		end
	end

	// Hold the item's details until its result is formed.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_word.command;
			k_q   <= req.count;
			lo_q  <= req.start[bfc_pkg::LANE_W-1:0];
			ovf_q <= (in_word.command == bfc_pkg::CMD_PUSH) && ovf;
			if (in_word.command == bfc_pkg::CMD_SET_POPPED) begin
				old_q <= pop_sum_q;
			end else if (in_word.command == bfc_pkg::CMD_SET_QUEUED) begin
				old_q <= que_sum_q;
			end else begin
				old_q <= 8'h00;
			end
		end
	end

	// Output register: decouples the result from the next accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q.read_data    <= (cmd_q == bfc_pkg::CMD_POP || cmd_q == bfc_pkg::CMD_PEEK)
				? mrg_data : 32'h0;
			out_q.old_checksum <= old_q;
			out_q.fill_level   <= 11'(held_q);
			out_q.is_empty     <= (held_q == '0);
			out_q.overflowed   <= ovf_q;
			out_q.popped_sum   <= (cmd_q == bfc_pkg::CMD_POP) ? pop_sum_q + mrg_sum
				: pop_sum_q;
			out_q.queued_sum   <= que_sum_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_q;

endmodule

### design/bfc_ram.sv
module bfc_ram #(
	parameter int WIDTH = 8,
	parameter int WORDS = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic                                   re,
	input  logic [((WORDS > 1) ? $clog2(WORDS) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                       wdata,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [WORDS];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

### design/bfc_lane.sv
module bfc_lane (
	input  logic                        clk,
	input  logic [bfc_pkg::LANE_W-1:0]  lane_id,
	input  bfc_pkg::lane_req_t          req,
	output logic [7:0]                  rdata
);

	localparam int ROW_W = (bfc_pkg::BANK_DEPTH > 1) ? $clog2(bfc_pkg::BANK_DEPTH) : 1;

	logic [bfc_pkg::LANE_W-1:0] idx;
	logic [bfc_pkg::PTR_W-1:0]  addr;
	logic [ROW_W-1:0]           row;
	logic                       we;
	logic                       re;
	logic [7:0]                 wdata;

	// Byte idx of the word lands in this lane.
	assign idx   = lane_id - req.start[bfc_pkg::LANE_W-1:0];
	assign addr  = bfc_pkg::ring_add(req.start, 3'(idx));
	assign row   = ROW_W'(addr >> bfc_pkg::LANE_W);
	assign we    = req.en & req.wr & ({1'b0, idx} < req.count);
	assign re    = req.en & ~req.wr;
	assign wdata = req.data[{idx, 3'b000} +: 8];

	bfc_ram #(
		.WIDTH(8),
		.WORDS(bfc_pkg::BANK_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.re   (re),
		.addr (row),
		.wdata(wdata),
		.rdata(rdata)
	);

endmodule

### design/bfc_merge.sv
module bfc_merge (
	input  logic [bfc_pkg::LANES-1:0][7:0] lane_rd,
	input  logic [bfc_pkg::LANE_W-1:0]     start_lo,
	input  logic [2:0]                     count,
	output logic [31:0]                    read_data,
	output logic [7:0]                     sum
);

	logic [31:0] gathered;

	// Rotate lane bytes back into word order, then drop missing bytes.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			gathered[8*i +: 8] = lane_rd[start_lo + bfc_pkg::LANE_W'(i)];
		end
		read_data = bfc_pkg::mask_bytes(gathered, count);
		sum       = bfc_pkg::byte_sum(read_data);
	end

endmodule

### design/bfc_checker.sv
module bfc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input bfc_pkg::in_t  in_word,
	input logic          out_valid,
	input logic          out_ready,
	input bfc_pkg::out_t out_word
);

	// A stalled result holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("result changed while stalled");

	// One word in flight: no accept right after an accept.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word taken while one is in flight");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.is_empty == (out_word.fill_level == 11'd0))
		else $error("empty flag disagrees with fill level");

	// A dropped byte means the queue is full afterwards.
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.overflowed |-> out_word.fill_level == 11'(bfc_pkg::DEPTH))
		else $error("overflow reported with room left");

endmodule

bind byte_fifo_with_checksums_top bfc_checker u_bfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (in_valid),
	.in_ready (in_ready),
	.in_word  (in_word),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_word (out_word)
);

### verif/byte_queue_checker.sv
`timescale 1ns / 100ps
module byte_queue_checker import bfc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_ready,
	input  in_t  in_word,
	input  logic out_valid,
	input  logic out_ready,
	input  out_t out_word,
	output int   mismatches,
	output int   outstanding
);

	logic [7:0]  ring_image [DEPTH];
	int unsigned head_idx = 0;
	int unsigned tail_idx = 0;
	int unsigned held = 0;
	logic [7:0]  popped_total = 8'h00;
	logic [7:0]  queued_total = 8'h00;
	out_t        expected_results [$];
	int          error_tally = 0;

	// Apply one command word to the queue image and return the result word it yields.
	function automatic out_t step_queue(input in_t w);
		out_t        r;
		int unsigned n;
		int unsigned rel;
		logic [7:0]  b;
		r = '0;
		n = (w.byte_count > 3'd4) ? 4 : int'(w.byte_count);
		case (w.command)
			CMD_PUSH: begin
				for (int i = 0; i < n; i++) begin
					b = w.push_data[8*i +: 8];
					if (held < DEPTH) begin
						ring_image[tail_idx] = b;
						tail_idx = (tail_idx + 1) % DEPTH;
						held++;
						queued_total = queued_total + b;
					end else begin
						r.overflowed = 1'b1;
					end
				end
			end
			CMD_POP: begin
				for (int i = 0; i < n; i++) begin
					if (held > 0) begin
						b = ring_image[head_idx];
						head_idx = (head_idx + 1) % DEPTH;
						held--;
						popped_total = popped_total + b;
						r.read_data[8*i +: 8] = b;
					end
				end
			end
			CMD_PEEK: begin
				for (int i = 0; i < n; i++) begin
					rel = int'(w.peek_offset) + i;
					if (rel < held) begin
						r.read_data[8*i +: 8] = ring_image[(head_idx + rel) % DEPTH];
					end
				end
			end
			CMD_CLEAR: begin
				head_idx = 0;
				tail_idx = 0;
				held = 0;
			end
			CMD_SET_POPPED: begin
				r.old_checksum = popped_total;
				popped_total = w.new_checksum;
			end
			CMD_SET_QUEUED: begin
				r.old_checksum = queued_total;
				queued_total = w.new_checksum;
			end
			default: begin
			end
		endcase
		r.fill_level = 11'(held);
		r.is_empty = (held == 0);
		r.popped_sum = popped_total;
		r.queued_sum = queued_total;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_tally++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			head_idx = 0;
			tail_idx = 0;
			held = 0;
			popped_total = 8'h00;
			queued_total = 8'h00;
			expected_results.delete();
			outstanding <= 0;
		end else begin
			// Retire the result first: it belongs to an older command than one taken now.
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$error("result word %h with no command pending", out_word);
					error_tally++;
				end else begin
					want = expected_results.pop_front();
					check_field("read_data", want.read_data, out_word.read_data);
					check_field("old_checksum", 32'(want.old_checksum), 32'(out_word.old_checksum));
					check_field("fill_level", 32'(want.fill_level), 32'(out_word.fill_level));
					check_field("is_empty", 32'(want.is_empty), 32'(out_word.is_empty));
					check_field("overflowed", 32'(want.overflowed), 32'(out_word.overflowed));
					check_field("popped_sum", 32'(want.popped_sum), 32'(out_word.popped_sum));
					check_field("queued_sum", 32'(want.queued_sum), 32'(out_word.queued_sum));
				end
			end
			if (in_valid && in_ready) begin
				expected_results.push_back(step_queue(in_word));
			end
			outstanding <= expected_results.size();
		end
		mismatches <= error_tally;
	end

endmodule

### verif/tb_byte_fifo_with_checksums_top.sv
`timescale 1ns / 100ps
module tb_byte_fifo_with_checksums_top;
	import bfc_pkg::*;

	// Command codes the block leaves unused; they must pass through as no-ops.
	localparam logic [2:0] CMD_SPARE_6 = 3'd6;
	localparam logic [2:0] CMD_SPARE_7 = 3'd7;
	// Cycles without any word moving on either channel before the run is declared hung.
	localparam int QUIET_LIMIT = 4000;
	// Settle time after the last result, with margin for the pipeline to go quiet.
	localparam int TAIL_CYCLES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_t  in_word = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_word;
	int   mismatches;
	int   outstanding;

	// Idling on both channels is enabled per stretch; the closing stretch runs without it.
	bit          idle_on = 1'b1;
	int unsigned sink_hold = 0;
	int unsigned quiet_cycles = 0;

	always #10 clk = ~clk;

	byte_fifo_with_checksums_top DUT (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_word,
		.out_valid,
		.out_ready,
		.out_word
	);

	byte_queue_checker queue_checker (
		.clk,
		.arst_n,
		.in_valid,
		.in_ready,
		.in_word,
		.out_valid,
		.out_ready,
		.out_word,
		.mismatches,
		.outstanding
	);

	// Result side: stall in bursts of random length while idling is on, otherwise take every word.
	always @(posedge clk) begin
		if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			sink_hold <= $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: end the run if neither channel moves a word for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_byte_fifo_with_checksums_top failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_t word_of(input logic [2:0] cmd, input logic [31:0] data,
			input logic [2:0] cnt, input logic [9:0] ofs, input logic [7:0] sum);
		in_t w;
		w.command = cmd;
		w.push_data = data;
		w.byte_count = cnt;
		w.peek_offset = ofs;
		w.new_checksum = sum;
		return w;
	endfunction

	// Build one random command word. Unused fields carry random noise on purpose.
	// The share of pushes and pops steers the fill level; full_bytes favors 4-byte moves
	// so the queue fills and drains fast enough to reach the full and empty corners.
	function automatic in_t random_word(input int unsigned push_pct,
			input int unsigned pop_pct, input bit full_bytes, input bit allow_clear);
		in_t         w;
		int unsigned pick;
		int unsigned rest;
		w.push_data = $urandom();
		w.new_checksum = 8'($urandom_range(0, 255));
		case ($urandom_range(0, 2))
			0: w.peek_offset = 10'($urandom_range(0, 7));
			1: w.peek_offset = 10'($urandom_range(0, 1023));
			default: w.peek_offset = 10'($urandom_range(1016, 1023));
		endcase
		// Occasionally use the out-of-range counts: zero moves nothing, above four clamps.
		if ($urandom_range(0, 9) == 0) begin
			w.byte_count = 3'($urandom_range(0, 7));
		end else if (full_bytes && $urandom_range(0, 4) != 0) begin
			w.byte_count = 3'd4;
		end else begin
			w.byte_count = 3'($urandom_range(1, 4));
		end
		pick = $urandom_range(0, 99);
		rest = $urandom_range(0, 19);
		if (pick < push_pct) begin
			w.command = CMD_PUSH;
		end else if (pick < push_pct + pop_pct) begin
			w.command = CMD_POP;
		end else if (rest < 10) begin
			w.command = CMD_PEEK;
		end else if (rest < 13) begin
			w.command = CMD_SET_POPPED;
		end else if (rest < 16) begin
			w.command = CMD_SET_QUEUED;
		end else if (rest == 16) begin
			w.command = CMD_SPARE_6;
		end else if (rest == 17) begin
			w.command = CMD_SPARE_7;
		end else begin
			w.command = allow_clear ? CMD_CLEAR : CMD_PEEK;
		end
		return w;
	endfunction

	// Present one command word and hold it until the block takes it.
	// Called at an edge; returns at the edge where the word was accepted.
	task automatic send_word(input in_t w);
		if (idle_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_word <= w;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and hold off until every predicted result has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// Run a stretch of random words; re-pick idling every 40 words when allowed.
	task automatic random_phase(input int unsigned count, input int unsigned push_pct,
			input int unsigned pop_pct, input bit full_bytes, input bit allow_clear,
			input bit allow_idle);
		for (int unsigned k = 0; k < count; k++) begin
			if (k % 40 == 0) begin
				idle_on <= allow_idle && ($urandom_range(0, 3) != 0);
			end
			send_word(random_word(push_pct, pop_pct, full_bytes, allow_clear));
		end
	endtask

	initial begin
		in_t directed [$];

		// Hold reset from the start, then release it once for the whole run.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed corners: empty reads, count clamping, partial peeks and pops,
		// checksum loads at both extremes, clear, and the unused commands.
		directed.push_back(word_of(CMD_POP, 32'h0000_0000, 3'd4, 10'd0, 8'h00));
		directed.push_back(word_of(CMD_PEEK, 32'hFFFF_FFFF, 3'd4, 10'd0, 8'hFF));
		directed.push_back(word_of(CMD_PUSH, 32'hFFFF_FFFF, 3'd4, 10'd0, 8'h00));
		directed.push_back(word_of(CMD_PUSH, 32'h1234_5678, 3'd0, 10'd0, 8'h00));
		directed.push_back(word_of(CMD_PUSH, 32'hA5A5_A5A5, 3'd7, 10'd1023, 8'h00));
		directed.push_back(word_of(CMD_PUSH, 32'h0000_0000, 3'd1, 10'd0, 8'h00));
		directed.push_back(word_of(CMD_PEEK, 32'h0000_0000, 3'd4, 10'd0, 8'h00));
		directed.push_back(word_of(CMD_PEEK, 32'h0000_0000, 3'd4, 10'd6, 8'h00));
		directed.push_back(word_of(CMD_PEEK, 32'h0000_0000, 3'd4, 10'd1023, 8'h00));
		directed.push_back(word_of(CMD_PEEK, 32'h0000_0000, 3'd0, 10'd0, 8'h00));
		directed.push_back(word_of(CMD_POP, 32'h0000_0000, 3'd5, 10'd0, 8'h00));
		directed.push_back(word_of(CMD_POP, 32'h0000_0000, 3'd2, 10'd0, 8'h00));
		directed.push_back(word_of(CMD_SET_POPPED, 32'h0000_0000, 3'd1, 10'd0, 8'hFF));
		directed.push_back(word_of(CMD_SET_POPPED, 32'h0000_0000, 3'd1, 10'd0, 8'h00));
		directed.push_back(word_of(CMD_SET_QUEUED, 32'h0000_0000, 3'd1, 10'd0, 8'hFF));
		directed.push_back(word_of(CMD_SET_QUEUED, 32'h0000_0000, 3'd1, 10'd0, 8'h00));
		directed.push_back(word_of(CMD_CLEAR, 32'hFFFF_FFFF, 3'd7, 10'd1023, 8'hFF));
		directed.push_back(word_of(CMD_POP, 32'h0000_0000, 3'd1, 10'd0, 8'h00));
		directed.push_back(word_of(CMD_SPARE_6, 32'hFFFF_FFFF, 3'd4, 10'd1023, 8'hFF));
		directed.push_back(word_of(CMD_SPARE_7, 32'hFFFF_FFFF, 3'd4, 10'd1023, 8'hFF));
		directed.push_back(word_of(CMD_PUSH, 32'h0102_0304, 3'd3, 10'd0, 8'h00));
		directed.push_back(word_of(CMD_POP, 32'h0000_0000, 3'd4, 10'd0, 8'h00));
		foreach (directed[i]) begin
			send_word(directed[i]);
		end

		// Pause the sender until the pipeline is empty.
		wait_drained();

		// Mixed traffic at a low fill level, clears allowed.
		random_phase(150, 35, 30, 1'b0, 1'b1, 1'b1);
		// Fill past capacity so pushes overflow and long peeks see real data.
		random_phase(330, 90, 3, 1'b1, 1'b0, 1'b1);
		wait_drained();
		// Churn near full so both pointers wrap around the ring.
		random_phase(100, 45, 45, 1'b1, 1'b0, 1'b1);
		// Drain to empty and keep popping an empty queue.
		random_phase(300, 5, 85, 1'b1, 1'b0, 1'b1);
		// Closing stretch at full rate: no idling on either side.
		idle_on <= 1'b0;
		wait_drained();
		random_phase(150, 35, 30, 1'b0, 1'b1, 1'b0);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("tb_byte_fifo_with_checksums_top passed");
		end else begin
			$display("tb_byte_fifo_with_checksums_top failed");
		end
		$finish;
	end

endmodule

### files.f
design/bfc_pkg.sv
design/bfc_ram.sv
design/bfc_lane.sv
design/bfc_merge.sv
design/byte_fifo_with_checksums_top.sv
design/bfc_checker.sv
verif/byte_queue_checker.sv
verif/tb_byte_fifo_with_checksums_top.sv
